// File: sv/sorted_priority_queue_top_macros.svh
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// clocked assertion helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// property checked while out of reset
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// sizes, entry type and codes of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY   = 16;
    localparam int PRIO_BITS  = 16;
    localparam int VALUE_BITS = 32;
    localparam int IN_PRIO_BITS = 16;
    localparam int OCC_BITS   = 5;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [PRIO_BITS-1:0]         prio;
    } t_entry;

    // per cell load select, at most one set
    typedef struct packed {
        logic take_new;
        logic take_left;
        logic take_right;
    } t_cell_ctrl;

endpackage

// File: sv/spq_in_if.sv
// ----------------------------------------------------------------------------
// spq_in_if
// request channel: operation, value and priority with valid/ready
// ----------------------------------------------------------------------------
interface spq_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  operation;
    logic signed [spq_pkg::VALUE_BITS-1:0] item_value;
    logic [spq_pkg::IN_PRIO_BITS-1:0]      item_priority;

    modport source (output valid, output operation, output item_value,
                    output item_priority, input ready);
    modport sink   (input valid, input operation, input item_value,
                    input item_priority, output ready);
endinterface

// File: sv/spq_out_if.sv
// ----------------------------------------------------------------------------
// spq_out_if
// result channel: removed value, status flags and occupancy with valid/ready
// ----------------------------------------------------------------------------
interface spq_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [spq_pkg::VALUE_BITS-1:0] removed_value;
    logic                                  removed_valid;
    logic                                  underflow;
    logic                                  overflow;
    logic [spq_pkg::OCC_BITS-1:0]          occupancy;

    modport source (output valid, output removed_value, output removed_valid,
                    output underflow, output overflow, output occupancy,
                    input ready);
    modport sink   (input valid, input removed_value, input removed_valid,
                    input underflow, input overflow, input occupancy,
                    output ready);
endinterface

// File: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry, compares, loads from a neighbor
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occupied,
    input  spq_pkg::t_entry     i_new,
    input  spq_pkg::t_entry     i_left,
    input  spq_pkg::t_entry     i_right,
    output spq_pkg::t_entry     o_entry,
    output logic                o_gt
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // an empty slot counts as greater so the new entry lands at the tail
    assign o_gt = !i_occupied || (r_entry.prio > i_new.prio);

    always_comb begin
        priority if (i_ctrl.take_new) begin
            n_entry = i_new;
        end else if (i_ctrl.take_left) begin
            n_entry = i_left;
        end else if (i_ctrl.take_right) begin
            n_entry = i_right;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// File: sv/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// bounded stable min-first priority queue built as a shifting chain of cells
// ----------------------------------------------------------------------------
// use:
//   i_in  carries one request per transfer: operation insert or delete,
//         item_value and item_priority (smaller number leaves first)
//   o_out carries exactly one result per request: removed value and flag,
//         underflow, overflow and the occupancy after the request
//   every cell compares its priority with the incoming one in parallel, so an
//   insert or delete finishes in the cycle of its transfer; the result is
//   registered and shows in the cycle after the request transfer
//   throughput is one request per cycle unless the receiver stalls, set by the
//   chain update and the one-deep output register; i_in.ready is high while
//   the output register is empty or its result transfers in the same cycle
//   a stalled receiver holds the result, and while it waits i_in.ready
//   stays low, so no further request is taken until the result is taken
//   reset empties the queue (count to zero) and clears the output valid;
//   cell contents are left as they are and only slots below the count matter
//   equal priorities leave in arrival order; insert into a full queue is
//   dropped with overflow, delete on an empty queue gives underflow and zero
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_in_if.sink     i_in,
    spq_out_if.source  o_out
);

    localparam int CAP = spq_pkg::CAPACITY;
    localparam int PB  = spq_pkg::PRIO_BITS;
    localparam int CB  = spq_pkg::COUNT_BITS;
    localparam int OB  = spq_pkg::OCC_BITS;

    spq_pkg::t_count r_count;
    spq_pkg::t_count n_count;

    logic r_out_valid;
    logic signed [spq_pkg::VALUE_BITS-1:0] r_removed_value;
    logic r_removed_valid;
    logic r_underflow;
    logic r_overflow;

    logic in_fire;
    logic is_insert;
    logic is_full;
    logic is_empty;
    logic do_ins;
    logic do_del;

    spq_pkg::t_entry new_entry;
    spq_pkg::t_entry entries [CAP];
    logic [CAP-1:0]  gt;

    // output register frees up when empty or when its result transfers now
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign is_insert  = (i_in.operation == spq_pkg::OP_INSERT);
    assign is_full    = (r_count == CB'(CAP));
    assign is_empty   = (r_count == '0);
    assign do_ins     = in_fire && is_insert && !is_full;
    assign do_del     = in_fire && !is_insert && !is_empty;

    assign new_entry.value = i_in.item_value;
    assign new_entry.prio  = PB'(i_in.item_priority);

    // the chain: slot 0 is the head
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        spq_pkg::t_cell_ctrl ctrl;
        spq_pkg::t_entry     left_entry;
        spq_pkg::t_entry     right_entry;
        logic                prev_gt;

        if (g == 0) begin : g_head
            assign left_entry = new_entry;
            assign prev_gt    = 1'b0;
        end else begin : g_body
            assign left_entry = entries[g-1];
            assign prev_gt    = gt[g-1];
        end

        if (g == CAP - 1) begin : g_tail
            // tail has no right neighbor, it just holds on delete
            assign right_entry     = entries[g];
            assign ctrl.take_right = 1'b0;
        end else begin : g_mid
            assign right_entry     = entries[g+1];
            assign ctrl.take_right = do_del;
        end

        // first greater slot takes the new entry, everything after shifts down
        assign ctrl.take_new  = do_ins && gt[g] && !prev_gt;
        assign ctrl.take_left = do_ins && prev_gt;

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (ctrl),
            .i_occupied (r_count > CB'(g)),
            .i_new      (new_entry),
            .i_left     (left_entry),
            .i_right    (right_entry),
            .o_entry    (entries[g]),
            .o_gt       (gt[g])
        );
    end

    // occupancy count
    always_comb begin
        priority if (do_ins) begin
            n_count = r_count + CB'(1);
        end else if (do_del) begin
            n_count = r_count - CB'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_removed_value <= do_del ? entries[0].value : '0;
            r_removed_valid <= do_del;
            r_underflow     <= !is_insert && is_empty;
            r_overflow      <= is_insert && is_full;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.removed_value = r_removed_value;
    assign o_out.removed_valid = r_removed_valid;
    assign o_out.underflow     = r_underflow;
    assign o_out.overflow      = r_overflow;
    assign o_out.occupancy     = OB'(r_count);

endmodule

// File: sv/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks of the sorted priority queue, bound to the top level
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_top_macros.svh"

module spq_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic signed [spq_pkg::VALUE_BITS-1:0] i_removed_value,
    input logic                                  i_removed_valid,
    input logic                                  i_underflow,
    input logic                                  i_overflow,
    input logic [spq_pkg::OCC_BITS-1:0]          i_occupancy
);

    localparam int OB = spq_pkg::OCC_BITS;

    `SPQ_ASSERT_ALWAYS(a_no_valid_after_reset, !i_rst_n |=> !i_out_valid, "result valid after reset")

    `SPQ_ASSERT(a_flags_exclusive, i_out_valid |-> !(i_removed_valid && i_underflow) && !(i_removed_valid && i_overflow) && !(i_underflow && i_overflow), "more than one status flag")

    `SPQ_ASSERT(a_underflow_empty, i_out_valid && i_underflow |-> i_occupancy == '0 && i_removed_value == '0, "underflow with entries or value")

    `SPQ_ASSERT(a_overflow_full, i_out_valid && i_overflow |-> i_occupancy == OB'(spq_pkg::CAPACITY), "overflow below capacity")

    `SPQ_ASSERT(a_stall_holds, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_removed_value) && $stable(i_occupancy), "stalled result changed")

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_removed_value (o_out.removed_value),
    .i_removed_valid (o_out.removed_valid),
    .i_underflow     (o_out.underflow),
    .i_overflow      (o_out.overflow),
    .i_occupancy     (o_out.occupancy)
);
